FILE: hdl/tepq_pkg.sv
package tepq_pkg;

  // One stored event.
  typedef struct packed {
    logic [31:0] stamp;
    logic [7:0]  kind;
    logic [14:0] source;
    logic [14:0] target;
    logic [31:0] payload;
  } entry_t;

  // What every cell of the chain does each cycle.
  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_ROTATE,
    MODE_DROP,
    MODE_APPEND
  } mode_e;

  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_REMOVE  = 2'd1;
  localparam logic [1:0] OP_PROCESS = 2'd2;

  localparam logic [2:0] STATUS_PUSHED  = 3'd0;
  localparam logic [2:0] STATUS_FULL    = 3'd1;
  localparam logic [2:0] STATUS_REMOVED = 3'd2;
  localparam logic [2:0] STATUS_DUE     = 3'd3;
  localparam logic [2:0] STATUS_NONE    = 3'd4;

  localparam logic [1:0] CLASS_RESET   = 2'd0;
  localparam logic [1:0] CLASS_UNREG   = 2'd1;
  localparam logic [1:0] CLASS_OTHER   = 2'd2;
  localparam logic [1:0] CLASS_NOTE    = 2'd3;

  // Indexes of the type code registers on the configuration port.
  localparam logic [1:0] REG_RESET_CODE  = 2'd0;
  localparam logic [1:0] REG_UNREG_CODE  = 2'd1;
  localparam logic [1:0] REG_NOTEON_CODE = 2'd2;
  localparam logic [1:0] REG_NOTE_CODE   = 2'd3;

  // Ordering class of a type code; the first matching register wins.
  function automatic logic [1:0] kind_class(input logic [7:0] kind,
                                            input logic [7:0] reset_code,
                                            input logic [7:0] unreg_code,
                                            input logic [7:0] noteon_code,
                                            input logic [7:0] note_code);
    logic [1:0] cls;
    if (kind == reset_code) begin
      cls = CLASS_RESET;
    end else if (kind == unreg_code) begin
      cls = CLASS_UNREG;
    end else if (kind == noteon_code || kind == note_code) begin
      cls = CLASS_NOTE;
    end else begin
      cls = CLASS_OTHER;
    end
    return cls;
  endfunction

endpackage

FILE: hdl/timestamp_event_priority_queue.sv
// Channel   Direction  Handshake                Beat contents
// request   in         start & !busy            op, stamp, kind_code, source_id, target_id, payload
// result    out        result_valid_o (1 cycle) status, event fields, removed_count, last
// config    in         cfg_we_i                 cfg_idx_i selects register, cfg_data_i value
//
// A push rotates each stored entry past the head and appends the new event where its place comes
// up; a remove rotates or drops each stored entry; a process issues one beat per due event (one
// beat when nothing is due); a push into a full queue answers without rotating. The ring rotation
// of the cell chain moves one entry past the head per cycle. Reset is asynchronous and active low;
// it empties the queue and restores the type code registers. The receiver cannot stall: every
// result beat is shown for exactly one cycle, and busy stays high until the final beat is issued.
module timestamp_event_priority_queue import tepq_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op_i,
  input  logic [31:0]        stamp_i,
  input  logic signed [8:0]  kind_code_i,
  input  logic signed [15:0] source_id_i,
  input  logic signed [15:0] target_id_i,
  input  logic [31:0]        payload_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  output logic               result_valid_o,
  output logic [2:0]         status_o,
  output logic [31:0]        out_stamp_o,
  output logic [7:0]         out_kind_o,
  output logic [14:0]        out_source_o,
  output logic [14:0]        out_target_o,
  output logic [31:0]        out_payload_o,
  output logic [6:0]         removed_count_o,
  output logic               last_o
);

  localparam int unsigned OccW = $clog2(CAPACITY + 1);
  localparam logic [OccW-1:0] Full = OccW'(CAPACITY);
  localparam logic [OccW-1:0] One  = OccW'(1);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_PUSH    = 2'd1;
  localparam logic [1:0] ST_REMOVE  = 2'd2;
  localparam logic [1:0] ST_PROCESS = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [OccW-1:0] occ_q, occ_d;
  logic [OccW-1:0] rem_q, rem_d;
  logic [OccW-1:0] cnt_q, cnt_d;
  logic            ins_q, ins_d;

  logic [7:0] reset_code_q, unreg_code_q, noteon_code_q, note_code_q;

  // Request captured when it is accepted.
  logic [31:0]        req_stamp_q;
  logic signed [8:0]  req_kind_q;
  logic signed [15:0] req_source_q;
  logic signed [15:0] req_target_q;
  logic [31:0]        req_payload_q;

  logic        res_valid_q, res_valid_d;
  logic [2:0]  res_status_q, res_status_d;
  entry_t      res_entry_q, res_entry_d;
  logic [OccW-1:0] res_count_q, res_count_d;
  logic        res_last_q, res_last_d;

  mode_e  mode;
  entry_t cells [CAPACITY];
  entry_t new_entry;
  entry_t head, second;
  logic   accept;
  logic   head_first, head_match, head_due, second_due;
  logic [1:0] head_cls, new_cls;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  assign new_entry.stamp   = req_stamp_q;
  assign new_entry.kind    = req_kind_q[7:0];
  assign new_entry.source  = req_source_q[14:0];
  assign new_entry.target  = req_target_q[14:0];
  assign new_entry.payload = req_payload_q;

  assign head   = cells[0];
  assign second = cells[1];

  // The chain itself: each cell sees the head, its right-hand neighbour and the new event.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t right;
    if (i == CAPACITY - 1) begin : g_end
      assign right = '0;
    end else begin : g_mid
      assign right = cells[i+1];
    end
    tepq_cell #(
      .Idx  (i),
      .OccW (OccW)
    ) u_cell (
      .clk_i   (clk_i),
      .mode_i  (mode),
      .len_i   (occ_q),
      .head_i  (head),
      .right_i (right),
      .new_i   (new_entry),
      .entry_o (cells[i])
    );
  end

  assign head_cls = kind_class(head.kind, reset_code_q, unreg_code_q, noteon_code_q,
                               note_code_q);
  assign new_cls  = kind_class(new_entry.kind, reset_code_q, unreg_code_q, noteon_code_q,
                               note_code_q);

  // The stored head leaves before the new event.
  assign head_first = (head.stamp != req_stamp_q) ? (head.stamp < req_stamp_q)
                                                  : (head_cls <= new_cls);

  // A filter of all ones is the wildcard; any other negative filter matches nothing.
  assign head_match =
      ((&req_source_q) || (!req_source_q[15] && head.source == req_source_q[14:0])) &&
      ((&req_target_q) || (!req_target_q[15] && head.target == req_target_q[14:0])) &&
      ((&req_kind_q)   || (!req_kind_q[8]    && head.kind   == req_kind_q[7:0]));

  assign head_due   = (occ_q != '0) && (head.stamp <= req_stamp_q);
  assign second_due = (occ_q > One) && (second.stamp <= req_stamp_q);

  always_comb begin
    state_d      = state_q;
    occ_d        = occ_q;
    rem_d        = rem_q;
    cnt_d        = cnt_q;
    ins_d        = ins_q;
    mode         = MODE_HOLD;
    res_valid_d  = 1'b0;
    res_status_d = res_status_q;
    res_entry_d  = '0;
    res_count_d  = '0;
    res_last_d   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rem_d = occ_q;
          cnt_d = '0;
          ins_d = 1'b0;
          priority if (op_i == OP_PUSH) begin
            if (occ_q == Full) begin
              res_valid_d  = 1'b1;
              res_status_d = STATUS_FULL;
              res_last_d   = 1'b1;
            end else begin
              state_d = ST_PUSH;
            end
          end else if (op_i == OP_REMOVE) begin
            state_d = ST_REMOVE;
          end else if (op_i == OP_PROCESS) begin
            state_d = ST_PROCESS;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_PUSH: begin
        // Rotate entries past the head until the new event's place comes up.
        if (rem_q == '0) begin
          if (!ins_q) begin
            mode  = MODE_APPEND;
            occ_d = occ_q + One;
          end
          res_valid_d  = 1'b1;
          res_status_d = STATUS_PUSHED;
          res_last_d   = 1'b1;
          state_d      = ST_IDLE;
        end else if (!ins_q && !head_first) begin
          mode  = MODE_APPEND;
          occ_d = occ_q + One;
          ins_d = 1'b1;
        end else begin
          mode  = MODE_ROTATE;
          rem_d = rem_q - One;
        end
      end
      ST_REMOVE: begin
        if (rem_q == '0) begin
          res_valid_d  = 1'b1;
          res_status_d = STATUS_REMOVED;
          res_count_d  = cnt_q;
          res_last_d   = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          rem_d = rem_q - One;
          if (head_match) begin
            mode  = MODE_DROP;
            occ_d = occ_q - One;
            cnt_d = cnt_q + One;
          end else begin
            mode = MODE_ROTATE;
          end
        end
      end
      ST_PROCESS: begin
        res_valid_d = 1'b1;
        if (head_due) begin
          mode         = MODE_DROP;
          occ_d        = occ_q - One;
          res_status_d = STATUS_DUE;
          res_entry_d  = head;
          res_last_d   = !second_due;
          if (!second_due) begin
            state_d = ST_IDLE;
          end
        end else begin
          res_status_d = STATUS_NONE;
          res_last_d   = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      occ_q         <= '0;
      rem_q         <= '0;
      cnt_q         <= '0;
      ins_q         <= 1'b0;
      res_valid_q   <= 1'b0;
      reset_code_q  <= 8'd20;
      unreg_code_q  <= 8'd21;
      noteon_code_q <= 8'd1;
      note_code_q   <= 8'd0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      rem_q       <= rem_d;
      cnt_q       <= cnt_d;
      ins_q       <= ins_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_RESET_CODE:  reset_code_q  <= cfg_data_i;
          REG_UNREG_CODE:  unreg_code_q  <= cfg_data_i;
          REG_NOTEON_CODE: noteon_code_q <= cfg_data_i;
          default:         note_code_q   <= cfg_data_i;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_stamp_q   <= stamp_i;
      req_kind_q    <= kind_code_i;
      req_source_q  <= source_id_i;
      req_target_q  <= target_id_i;
      req_payload_q <= payload_i;
    end
    res_status_q <= res_status_d;
    res_entry_q  <= res_entry_d;
    res_count_q  <= res_count_d;
    res_last_q   <= res_last_d;
  end

  assign result_valid_o  = res_valid_q;
  assign status_o        = res_status_q;
  assign out_stamp_o     = res_entry_q.stamp;
  assign out_kind_o      = res_entry_q.kind;
  assign out_source_o    = res_entry_q.source;
  assign out_target_o    = res_entry_q.target;
  assign out_payload_o   = res_entry_q.payload;
  assign removed_count_o = 7'(res_count_q);
  assign last_o          = res_last_q;

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= Full) else $error("occupancy beyond capacity");

  a_process_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROCESS) |=> (occ_q <= $past(occ_q)))
    else $error("processing grew the queue");

  a_single_beat_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != STATUS_DUE) |-> last_o)
    else $error("single-beat result without last");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |-> (state_q == ST_IDLE))
    else $error("busy after final beat");
`endif

endmodule

FILE: hdl/tepq_cell.sv
module tepq_cell import tepq_pkg::*; #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned OccW = 7
) (
  input  logic            clk_i,
  input  mode_e           mode_i,
  input  logic [OccW-1:0] len_i,
  input  entry_t          head_i,
  input  entry_t          right_i,
  input  entry_t          new_i,
  output entry_t          entry_o
);

  localparam logic [OccW-1:0] Here = OccW'(Idx);
  localparam logic [OccW-1:0] Next = OccW'(Idx + 1);

  entry_t entry_d, entry_q;

  always_comb begin
    entry_d = entry_q;
    unique case (mode_i)
      MODE_ROTATE: begin
        // The ring spans cells below len; the head re-enters at its far end.
        if (Next < len_i) begin
          entry_d = right_i;
        end else if (Next == len_i) begin
          entry_d = head_i;
        end
      end
      MODE_DROP:   entry_d = right_i;
      MODE_APPEND: begin
        if (Here == len_i) begin
          entry_d = new_i;
        end
      end
      default:     entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
